/* rtl/letter_frequency_ranker_assert.svh */
// ----------------------------------------------------------------------------
// letter_frequency_ranker assertion macros
// Concurrent checks sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LETTER_FREQUENCY_RANKER_ASSERT_SVH
`define LETTER_FREQUENCY_RANKER_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent
`define LFR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("letter_frequency_ranker: same-cycle check failed");

// Check a consequence in the cycle after its antecedent
`define LFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("letter_frequency_ranker: next-cycle check failed");

`endif

/* rtl/lfr_pkg.sv */
// ----------------------------------------------------------------------------
// lfr_pkg
// Payload types and fixed constants of the letter frequency ranker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfr_pkg;

	// Byte code of the first counted letter
	localparam logic [7:0] FIRST_LETTER = 8'h41;

	// One text byte
	typedef struct packed {
		logic [7:0] text_char;
		logic       end_of_text;
	} char_t;

	// One line of the ranked report
	typedef struct packed {
		logic [4:0]  alpha_letter;
		logic [15:0] alpha_count;
		logic [4:0]  ranked_letter;
		logic [15:0] ranked_count;
		logic        report_last;
	} report_t;

	// Sequencer states
	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_INC      = 7'b0000010,
		ST_RANK     = 7'b0000100,
		ST_RANK_END = 7'b0001000,
		ST_REP_RD   = 7'b0010000,
		ST_REP_WHO  = 7'b0100000,
		ST_REP_LOAD = 7'b1000000
	} state_t;

endpackage

/* rtl/letter_frequency_ranker.sv */
// ----------------------------------------------------------------------------
// letter_frequency_ranker
// Per-letter saturating histogram of a byte stream with a ranked report.
// ----------------------------------------------------------------------------
// Usage:
//   char channel (char_valid/char_ready/char_data) takes one text byte per
//   transfer; bytes 'A' onward, one per letter bin, are counted, others are
//   ignored. A byte flagged end_of_text is counted and then starts a report.
//   rep channel (rep_valid/rep_ready/rep_data) returns ALPHABET_SIZE lines;
//   line i holds letter i with its count and the letter of rank i with its
//   count (descending count, ties to the lower letter). report_last marks
//   the final line, after which all counts read as zero again.
// Sequence:
//   A plain byte is handled as a count memory read, then a write back.
//   The ranking pass runs one shared comparator over every letter pair,
//   then each report line is built from a count read, a ranked letter
//   read and a count read again.
// Reset clears all counts at once through per-bin valid bits, with no
// sweep. A stalled receiver holds the current line in the output register
// and pauses the report; the block accepts no byte until the report ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "letter_frequency_ranker_assert.svh"

module letter_frequency_ranker
	import lfr_pkg::*;
#(
	parameter int ALPHABET_SIZE = 26,
	parameter int COUNT_BITS    = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    char_valid,
	output logic    char_ready,
	input  char_t   char_data,
	output logic    rep_valid,
	input  logic    rep_ready,
	output report_t rep_data
);

	localparam int                IDX_W     = $clog2(ALPHABET_SIZE);
	localparam logic [7:0]        ALPHA_B   = 8'(ALPHABET_SIZE);
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(ALPHABET_SIZE - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	state_t state_q;

	// Count memory, per-bin valid bits and rank memory
	logic [COUNT_BITS-1:0] cnt_mem [ALPHABET_SIZE];
	logic [IDX_W-1:0]      rank_mem [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] valid_q;

	logic [COUNT_BITS-1:0] rd_a_q, rd_b_q;
	logic                  va_q, vb_q;
	logic [IDX_W-1:0]      rank_rd_q;

	logic [IDX_W-1:0] addr_a, addr_b;
	logic             cnt_we;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic             rank_we;
	logic [IDX_W-1:0] rank_widx;

	// Byte capture
	logic [7:0]       k_full;
	logic             is_letter;
	logic [IDX_W-1:0] k_q;
	logic             letter_q, end_q;

	// Ranking sequencer and comparator stage
	logic [IDX_W-1:0] a_q, b_q, r_q;
	logic [IDX_W-1:0] a_s1, b_s1;
	logic             cmp_vld_s1;
	logic [COUNT_BITS-1:0] ca, cb;
	logic             beats;
	logic [IDX_W-1:0] r_next;

	// Report
	logic [IDX_W-1:0] i_q;
	logic             rep_valid_q;
	report_t          rep_data_q;
	logic             ld_out;
	logic [IDX_W+4:0]      alpha_ext, rank_ext;
	logic [COUNT_BITS+15:0] ca_ext, cb_ext;

	logic accept;

	assign accept     = char_valid && char_ready;
	assign char_ready = (state_q == ST_IDLE);
	assign rep_valid  = rep_valid_q;
	assign rep_data   = rep_data_q;

	// Decode the letter bin of the incoming byte
	assign k_full    = char_data.text_char - FIRST_LETTER;
	assign is_letter = (char_data.text_char >= FIRST_LETTER) && (k_full < ALPHA_B);

	// Effective counts: a bin never written since the last clear reads zero
	assign ca = va_q ? rd_a_q : '0;
	assign cb = vb_q ? rd_b_q : '0;

	// Shared comparator: does letter b rank ahead of letter a
	assign beats  = (cb > ca) || ((cb == ca) && (b_s1 < a_s1));
	assign r_next = r_q + IDX_W'(beats);

	// Select memory read addresses
	always_comb begin
		addr_a = i_q;
		addr_b = rank_rd_q;
		unique case (state_q) inside
			ST_IDLE: begin
				addr_a = is_letter ? k_full[IDX_W-1:0] : '0;
			end
			ST_INC: begin
				addr_a = k_q;
			end
			ST_RANK, ST_RANK_END: begin
				addr_a = a_q;
				addr_b = b_q;
			end
			ST_REP_RD, ST_REP_WHO, ST_REP_LOAD: begin
				addr_a = i_q;
				addr_b = rank_rd_q;
			end
			default: begin
				addr_a = i_q;
				addr_b = rank_rd_q;
			end
		endcase
	end

	// Count write back and rank write
	assign cnt_we    = (state_q == ST_INC) && letter_q && (ca != COUNT_MAX);
	assign cnt_wdata = ca + COUNT_BITS'(1);
	assign rank_we   = (state_q == ST_RANK_END || state_q == ST_RANK) && cmp_vld_s1
		&& (b_s1 == LAST_IDX);
	assign rank_widx = r_next;

	assign ld_out = (state_q == ST_REP_LOAD) && (!rep_valid_q || rep_ready);

	// Count memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[k_q] <= cnt_wdata;
		end
		rd_a_q <= cnt_mem[addr_a];
		rd_b_q <= cnt_mem[addr_b];
	end

	// Rank memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[rank_widx] <= a_s1;
		end
		rank_rd_q <= rank_mem[i_q];
	end

	// Sample valid bits alongside the memory reads
	always_ff @(posedge clk) begin
		va_q <= valid_q[addr_a];
		vb_q <= valid_q[addr_b];
	end

	// Set valid on write back, drop all after the last report line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ld_out && (i_q == LAST_IDX)) begin
			valid_q <= '0;
		end else if (cnt_we) begin
			valid_q[k_q] <= 1'b1;
		end
	end

	// Capture the accepted byte
	always_ff @(posedge clk) begin
		if (accept) begin
			k_q      <= is_letter ? k_full[IDX_W-1:0] : '0;
			letter_q <= is_letter;
			end_q    <= char_data.end_of_text;
		end
	end

	// Comparator stage operands
	always_ff @(posedge clk) begin
		a_s1 <= a_q;
		b_s1 <= b_q;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			a_q        <= '0;
			b_q        <= '0;
			r_q        <= '0;
			i_q        <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_INC;
					end
				end
				ST_INC: begin
					a_q <= '0;
					b_q <= '0;
					r_q <= '0;
					state_q <= end_q ? ST_RANK : ST_IDLE;
				end
				ST_RANK: begin
					// Issue one letter pair per cycle
					cmp_vld_s1 <= 1'b1;
					if (b_q == LAST_IDX) begin
						b_q <= '0;
						if (a_q == LAST_IDX) begin
							state_q <= ST_RANK_END;
						end else begin
							a_q <= a_q + IDX_W'(1);
						end
					end else begin
						b_q <= b_q + IDX_W'(1);
					end
					if (cmp_vld_s1) begin
						r_q <= (b_s1 == LAST_IDX) ? '0 : r_next;
					end
				end
				ST_RANK_END: begin
					// Retire the last pair
					cmp_vld_s1 <= 1'b0;
					r_q        <= '0;
					i_q        <= '0;
					state_q    <= ST_REP_RD;
				end
				ST_REP_RD: begin
					state_q <= ST_REP_WHO;
				end
				ST_REP_WHO: begin
					state_q <= ST_REP_LOAD;
				end
				ST_REP_LOAD: begin
					if (ld_out) begin
						if (i_q == LAST_IDX) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + IDX_W'(1);
							state_q <= ST_REP_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Fit letter indices and counts to the report field widths
	assign alpha_ext = {5'b0, i_q};
	assign rank_ext  = {5'b0, rank_rd_q};
	assign ca_ext    = {16'b0, ca};
	assign cb_ext    = {16'b0, cb};

	// Output register: hold the line until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_valid_q <= 1'b0;
		end else if (ld_out) begin
			rep_valid_q <= 1'b1;
		end else if (rep_ready) begin
			rep_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			rep_data_q.alpha_letter  <= alpha_ext[4:0];
			rep_data_q.alpha_count   <= ca_ext[15:0];
			rep_data_q.ranked_letter <= rank_ext[4:0];
			rep_data_q.ranked_count  <= cb_ext[15:0];
			rep_data_q.report_last   <= (i_q == LAST_IDX);
		end
	end

	// Checks
	`LFR_ASSERT_SAME(a_rank_in_range, rank_we, rank_widx <= LAST_IDX)
	`LFR_ASSERT_NEXT(a_clear_after_report, ld_out && (i_q == LAST_IDX), valid_q == '0)
	`LFR_ASSERT_NEXT(a_one_byte_at_a_time, char_valid && char_ready, !char_ready)

endmodule
